// ===== rtl/ois_pkg.sv =====
package ois_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 64;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_TEST   = 3'd2;
  localparam logic [2:0] ACT_PEEK   = 3'd3;
  localparam logic [2:0] ACT_POP    = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_PREV = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;

  typedef struct packed {
    logic [2:0]                action;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                      success;
    logic signed [VALUE_W-1:0] min_value;
    logic [6:0]                entry_count;
    logic                      full_flag;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       idx_dec;
    logic       idx_to_cnt;
    logic       rd_en;
    logic [1:0] rd_mode;
    logic       wr_en;
    logic       wr_val;
    logic       found_set;
    logic       found_val;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       res_load;
    logic       res_success;
    logic       res_full;
    logic       respond;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       lt;
    logic       eq;
    logic       idx_end;
    logic       idx_at_pos;
    logic       idx_last;
    logic       found;
    logic       cnt_zero;
    logic       cnt_full;
  } status_t;

endpackage

// ===== rtl/ois_ram.sv =====
module ois_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ois_dp.sv =====
module ois_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ois_pkg::in_item_t in_item,
  input  ois_pkg::cmd_t     cmd,
  output ois_pkg::status_t  st,
  output logic              out_strobe,
  output ois_pkg::out_item_t out_item
);

  logic [2:0]                        act_r;
  logic signed [ois_pkg::VALUE_W-1:0] val_r;
  logic signed [ois_pkg::VALUE_W-1:0] minv_r;
  logic signed [ois_pkg::VALUE_W-1:0] min_r;
  logic signed [ois_pkg::VALUE_W-1:0] min_nxt;
  logic [ois_pkg::CNT_W-1:0]         idx_r;
  logic [ois_pkg::CNT_W-1:0]         idx_nxt;
  logic [ois_pkg::CNT_W-1:0]         pos_r;
  logic [ois_pkg::CNT_W-1:0]         cnt_r;
  logic [ois_pkg::CNT_W-1:0]         cnt_nxt;
  logic [ois_pkg::CNT_W-1:0]         raddr_full;
  logic [ois_pkg::CNT_W:0]           idx_plus1;
  logic                              found_r;
  logic                              res_success_r;
  logic                              res_full_r;
  logic                              out_strobe_r;
  ois_pkg::out_item_t                out_item_r;
  logic [ois_pkg::VALUE_W-1:0]       rdata;
  logic [ois_pkg::VALUE_W-1:0]       wdata;

  ois_ram #(
    .WIDTH(ois_pkg::VALUE_W),
    .DEPTH(ois_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(idx_r[ois_pkg::ADDR_W-1:0]),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(raddr_full[ois_pkg::ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign wdata     = cmd.wr_val ? val_r : rdata;
  assign idx_plus1 = {1'b0, idx_r} + 1'b1;

  always_comb begin
    case (cmd.rd_mode)
      ois_pkg::RD_IDX:  raddr_full = idx_r;
      ois_pkg::RD_PREV: raddr_full = idx_r - 1'b1;
      ois_pkg::RD_NEXT: raddr_full = idx_plus1[ois_pkg::CNT_W-1:0];
      default:          raddr_full = idx_r;
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_plus1[ois_pkg::CNT_W-1:0];
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - 1'b1;
    end else if (cmd.idx_to_cnt) begin
      idx_nxt = cnt_r;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // The head register mirrors slot zero of the store.
  always_comb begin
    min_nxt = min_r;
    if (cmd.wr_en && (idx_r == '0)) begin
      min_nxt = $signed(wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r         <= '0;
      pos_r         <= '0;
      cnt_r         <= '0;
      found_r       <= 1'b0;
      res_success_r <= 1'b0;
      res_full_r    <= 1'b0;
      out_strobe_r  <= 1'b0;
      act_r         <= ois_pkg::ACT_INSERT;
    end else begin
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= cmd.respond;
      if (cmd.load) begin
        act_r <= in_item.action;
      end
      if (cmd.found_set) begin
        found_r <= cmd.found_val;
        pos_r   <= idx_r;
      end
      if (cmd.res_load) begin
        res_success_r <= cmd.res_success;
        res_full_r    <= cmd.res_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    if (cmd.load) begin
      val_r  <= in_item.value;
      minv_r <= (cnt_r == '0) ? '0 : min_r;
    end
    if (cmd.respond) begin
      out_item_r.success     <= res_success_r;
      out_item_r.min_value   <= minv_r;
      out_item_r.entry_count <= 7'(cnt_r);
      out_item_r.full_flag   <= res_full_r;
    end
  end

  always_comb begin
    st.act        = act_r;
    st.lt         = $signed(rdata) < val_r;
    st.eq         = $signed(rdata) == val_r;
    st.idx_end    = idx_r >= cnt_r;
    st.idx_at_pos = idx_r == pos_r;
    st.idx_last   = idx_plus1 >= {1'b0, cnt_r};
    st.found      = found_r;
    st.cnt_zero   = cnt_r == '0;
    st.cnt_full   = cnt_r == ois_pkg::CNT_W'(ois_pkg::CAPACITY);
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== rtl/ois_ctrl.sv =====
module ois_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  ois_pkg::status_t st,
  output ois_pkg::cmd_t    cmd,
  output logic             busy
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_SRCH_RD  = 4'd2;
  localparam logic [3:0] S_SRCH_CMP = 4'd3;
  localparam logic [3:0] S_ACT      = 4'd4;
  localparam logic [3:0] S_INS_CHK  = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_REM_CHK  = 4'd7;
  localparam logic [3:0] S_REM_WR   = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.act)
          ois_pkg::ACT_INSERT, ois_pkg::ACT_REMOVE, ois_pkg::ACT_TEST: begin
            state_nxt = S_SRCH_RD;
          end
          ois_pkg::ACT_PEEK: begin
            cmd.res_load    = 1'b1;
            cmd.res_success = !st.cnt_zero;
            state_nxt       = S_DONE;
          end
          ois_pkg::ACT_POP: begin
            if (st.cnt_zero) begin
              cmd.res_load = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              state_nxt = S_REM_CHK;
            end
          end
          ois_pkg::ACT_CLEAR: begin
            cmd.cnt_clr     = 1'b1;
            cmd.res_load    = 1'b1;
            cmd.res_success = 1'b1;
            state_nxt       = S_DONE;
          end
          default: begin
            cmd.res_load = 1'b1;
            state_nxt    = S_DONE;
          end
        endcase
      end
      S_SRCH_RD: begin
        if (st.idx_end) begin
          cmd.found_set = 1'b1;
          state_nxt     = S_ACT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = ois_pkg::RD_IDX;
          state_nxt   = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (st.lt) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRCH_RD;
        end else begin
          cmd.found_set = 1'b1;
          cmd.found_val = st.eq;
          state_nxt     = S_ACT;
        end
      end
      S_ACT: begin
        case (st.act)
          ois_pkg::ACT_INSERT: begin
            if (st.found || st.cnt_full) begin
              cmd.res_load = 1'b1;
              cmd.res_full = !st.found;
              state_nxt    = S_DONE;
            end else begin
              cmd.idx_to_cnt = 1'b1;
              state_nxt      = S_INS_CHK;
            end
          end
          ois_pkg::ACT_REMOVE: begin
            if (st.found) begin
              state_nxt = S_REM_CHK;
            end else begin
              cmd.res_load = 1'b1;
              state_nxt    = S_DONE;
            end
          end
          default: begin
            cmd.res_load    = 1'b1;
            cmd.res_success = st.found;
            state_nxt       = S_DONE;
          end
        endcase
      end
      S_INS_CHK: begin
        if (st.idx_at_pos) begin
          cmd.wr_en       = 1'b1;
          cmd.wr_val      = 1'b1;
          cmd.cnt_inc     = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_success = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = ois_pkg::RD_PREV;
          state_nxt   = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_dec = 1'b1;
        state_nxt   = S_INS_CHK;
      end
      S_REM_CHK: begin
        if (st.idx_last) begin
          cmd.cnt_dec     = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_success = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_mode = ois_pkg::RD_NEXT;
          state_nxt   = S_REM_WR;
        end
      end
      S_REM_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_REM_CHK;
      end
      S_DONE: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = state_r != S_IDLE;

endmodule

// ===== rtl/ordered_integer_set.sv =====
// Channel   Ports                        Transfer
// input     start, busy, in_item         start high while busy is low
// result    out_strobe, out_item         out_strobe high for one cycle
//
// One transaction at a time; busy stays high from acceptance until the result is
// registered. Values sit in ascending order in a RAM with one write port and one
// registered read port; the search reads entries in turn while they are smaller,
// and an insert or remove shifts the later entries one at a time. Reset is
// synchronous and empties the set at once. The receiver cannot stall.
module ordered_integer_set (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ois_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output ois_pkg::out_item_t out_item
);

  ois_pkg::cmd_t    cmd;
  ois_pkg::status_t st;

  ois_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  ois_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule
